/* hdl/assert_macros.svh */
// Assertion macros for the vertex dedup indexer datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VTDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define VTDI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vtdi_pkg.sv */
// Shared types and constants for the vertex dedup indexer.
package vtdi_pkg;

  localparam int LANES       = 16;
  localparam int LANE_BITS   = 4;
  localparam int FIELD_W     = 16;
  localparam int MAX_SLOTS   = 4;
  localparam int OUT_IDX_W   = 10;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic capture;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more_rows;
    logic cmp_vld;
    logic hit;
    logic out_free;
  } status_t;

endpackage

/* hdl/vtdi_ctrl.sv */
// Control state machine: accept, row search, result writeback.
module vtdi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  vtdi_pkg::status_t st,
  output vtdi_pkg::cmd_t    cmd
);

  vtdi_pkg::state_t state_r;
  vtdi_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vtdi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      vtdi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = vtdi_pkg::ST_SEARCH;
        end
      end
      vtdi_pkg::ST_SEARCH: begin
        if (st.hit) begin
          cmd.capture = 1'b1;
          state_nxt   = vtdi_pkg::ST_FINISH;
        end else if (st.more_rows) begin
          cmd.issue = 1'b1;
        end else if (!st.cmp_vld) begin
          state_nxt = vtdi_pkg::ST_FINISH;
        end
      end
      vtdi_pkg::ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = vtdi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vtdi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/vtdi_datapath.sv */
// Datapath: banked tuple table, lane compare, merge and result register.
`include "assert_macros.svh"

module vtdi_datapath #(
  parameter int ENTRIES    = 1024,
  parameter int SLOTS      = 4,
  parameter int INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vtdi_pkg::cmd_t                      cmd,
  output vtdi_pkg::status_t                   st,
  input  logic                                new_mesh,
  input  logic [SLOTS-1:0]                    present_in,
  input  logic [SLOTS-1:0][INDEX_BITS-1:0]    vals_in,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [vtdi_pkg::OUT_IDX_W-1:0]      dense_idx,
  output logic                                is_new,
  output logic                                table_full
);

  localparam int LANES  = vtdi_pkg::LANES;
  localparam int LB     = vtdi_pkg::LANE_BITS;
  localparam int VAL_W  = SLOTS * INDEX_BITS;
  localparam int WORD_W = VAL_W + SLOTS;
  localparam int ROWS   = (ENTRIES + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCNT_W = $clog2(ROWS + 1);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CW     = LB + CNT_W + 1;

  logic [CNT_W-1:0]                 next_r;
  logic [SLOTS-1:0]                 present_r;
  logic [SLOTS-1:0][INDEX_BITS-1:0] vals_r;
  logic [RCNT_W-1:0]                rd_row_r;
  logic [ROW_W-1:0]                 cmp_row_r;
  logic                             cmp_vld_r;
  logic                             found_r;
  logic [ROW_W-1:0]                 sel_row_r;
  logic [LB-1:0]                    sel_lane_r;
  logic [WORD_W-1:0]                sel_word_r;
  logic                             out_valid_r;
  logic [vtdi_pkg::OUT_IDX_W-1:0]   out_idx_r;
  logic                             out_new_r;
  logic                             out_full_r;

  logic [WORD_W-1:0] lane_word [LANES];
  logic [LANES-1:0]  lane_hit;
  logic [LB-1:0]     hit_lane;
  logic [WORD_W-1:0] merged_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] wr_word;
  logic [ROW_W-1:0]  wr_row;
  logic [LB-1:0]     wr_lane;
  logic              wr_en;
  logic              full;
  logic [CW-1:0]     next_w;

  assign full   = (next_r >= CNT_W'(ENTRIES));
  assign next_w = CW'(next_r);

  // Table banks: one entry per lane per row.
  for (genvar l = 0; l < LANES; l++) begin : g_bank
    logic [WORD_W-1:0] mem [ROWS];
    logic [WORD_W-1:0] rd_q;
    always_ff @(posedge clk) begin
      if (wr_en && (wr_lane == LB'(l))) begin
        mem[wr_row] <= wr_word;
      end
      if (cmd.issue) begin
        rd_q <= mem[rd_row_r[ROW_W-1:0]];
      end
    end
    assign lane_word[l] = rd_q;
  end

  always_comb begin
    logic             agree;
    logic [SLOTS-1:0] m;
    logic [CW-1:0]    entry;
    lane_hit = '0;
    for (int l = 0; l < LANES; l++) begin
      m     = lane_word[l][VAL_W +: SLOTS];
      agree = 1'b1;
      for (int k = 0; k < SLOTS; k++) begin
        if (present_r[k] && m[k] &&
            (lane_word[l][k*INDEX_BITS +: INDEX_BITS] != vals_r[k])) begin
          agree = 1'b0;
        end
      end
      entry       = CW'({cmp_row_r, LB'(l)});
      lane_hit[l] = agree && (entry < next_w);
    end
  end

  always_comb begin
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane_hit[l]) begin
        hit_lane = LB'(l);
      end
    end
  end

  always_comb begin
    logic [WORD_W-1:0] hw;
    hw          = lane_word[hit_lane];
    merged_word = hw;
    new_word    = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (present_r[k]) begin
        merged_word[k*INDEX_BITS +: INDEX_BITS] = vals_r[k];
        new_word[k*INDEX_BITS +: INDEX_BITS]    = vals_r[k];
      end
    end
    merged_word[VAL_W +: SLOTS] = hw[VAL_W +: SLOTS] | present_r;
    new_word[VAL_W +: SLOTS]    = present_r;
  end

  assign wr_en   = cmd.finish && (found_r || !full);
  assign wr_word = found_r ? sel_word_r : new_word;
  assign wr_row  = found_r ? sel_row_r  : next_w[LB +: ROW_W];
  assign wr_lane = found_r ? sel_lane_r : next_w[LB-1:0];

  assign st.more_rows = ((CW'(rd_row_r) << LB) < next_w);
  assign st.cmp_vld   = cmp_vld_r;
  assign st.hit       = cmp_vld_r && (|lane_hit);
  assign st.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r      <= '0;
      rd_row_r    <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.issue;
      if (cmd.accept) begin
        if (new_mesh) begin
          next_r <= '0;
        end
        rd_row_r <= '0;
        found_r  <= 1'b0;
      end
      if (cmd.issue) begin
        rd_row_r <= rd_row_r + RCNT_W'(1);
      end
      if (cmd.capture) begin
        found_r <= 1'b1;
      end
      if (cmd.finish && !found_r && !full) begin
        next_r <= next_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      present_r <= present_in;
      vals_r    <= vals_in;
    end
    if (cmd.issue) begin
      cmp_row_r <= rd_row_r[ROW_W-1:0];
    end
    if (cmd.capture) begin
      sel_row_r  <= cmp_row_r;
      sel_lane_r <= hit_lane;
      sel_word_r <= merged_word;
    end
    if (cmd.finish) begin
      if (found_r) begin
        out_idx_r <= vtdi_pkg::OUT_IDX_W'({sel_row_r, sel_lane_r});
      end else if (full) begin
        out_idx_r <= '0;
      end else begin
        out_idx_r <= vtdi_pkg::OUT_IDX_W'(next_r);
      end
      out_new_r  <= !found_r && !full;
      out_full_r <= !found_r && full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign dense_idx  = out_idx_r;
  assign is_new     = out_new_r;
  assign table_full = out_full_r;

  `VTDI_ASSERT(a_count_bound, next_r <= CNT_W'(ENTRIES), "entry count beyond table size")
  `VTDI_ASSERT(a_flags_excl, !(out_valid_r && out_new_r && out_full_r),
               "result both new and full")
  `VTDI_ASSERT_NEXT(a_count_step, cmd.finish && !found_r && !full,
                    next_r == $past(next_r) + CNT_W'(1), "new entry did not advance count")

endmodule

/* hdl/vertex_tuple_dedup_indexer_core.sv */
// Top level of the vertex tuple dedup indexer.
//
//   channel | direction | tdata                      | tuser
//   in_     | slave     | index_a..index_d (64 bits) | new_mesh, slot_present
//   out_    | master    | dense index (16 bits)      | is_new, table_full
//
// With no match the search reads every row that holds a stored entry, all 16 lanes
// of a row in one bank read, and an empty table reads no row at all; a match in
// row j ends the scan there and the vertex goes on to writeback.
// Reset clears the entry count and handshake state; table contents need no clear.
// A finished result waits in the output register while the next beat is taken.
// A stalled output holds the block in writeback until the result register frees.
module vertex_tuple_dedup_indexer_core #(
  parameter int ENTRIES    = 1024,
  parameter int SLOTS      = 4,
  parameter int INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // index_a [15:0], index_b [31:16], index_c [47:32], index_d [63:48]
  input  logic [vtdi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // new_mesh [0], slot_present [4:1]
  input  logic [vtdi_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // dense index [9:0], zero fill [15:10]
  output logic [vtdi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // is_new [0], table_full [1]
  output logic [vtdi_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  vtdi_pkg::cmd_t    cmd;
  vtdi_pkg::status_t st;

  logic [SLOTS-1:0]                 present_in;
  logic [SLOTS-1:0][INDEX_BITS-1:0] vals_in;
  logic [vtdi_pkg::OUT_IDX_W-1:0]   dense_idx;
  logic                             is_new;
  logic                             table_full;

  assign present_in = in_tuser[1 +: SLOTS];

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    assign vals_in[k] = in_tdata[k*vtdi_pkg::FIELD_W +: INDEX_BITS];
  end

  vtdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  vtdi_datapath #(
    .ENTRIES    (ENTRIES),
    .SLOTS      (SLOTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .new_mesh     (in_tuser[0]),
    .present_in   (present_in),
    .vals_in      (vals_in),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .dense_idx    (dense_idx),
    .is_new       (is_new),
    .table_full   (table_full)
  );

  assign out_tdata = vtdi_pkg::OUT_TDATA_W'(dense_idx);
  assign out_tuser = {table_full, is_new};

endmodule
